[hw/rtl/kls_pkg.sv]
package kls_pkg;

  // fixed field widths
  localparam int VALUE_W = 32;
  localparam int CFG_W   = 7;

  // result status codes
  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_SHORT = 1'b1;

  // controller to datapath commands
  typedef struct packed {
    logic insert;   // insert the accepted sample into the chain
    logic report;   // load the result register and clear the set
  } kls_cmd_t;

endpackage

[hw/rtl/kls_datapath.sv]
module kls_datapath import kls_pkg::*; #(
  parameter int              MAX_RANK  = 64,
  parameter longint unsigned MAX_ITEMS = 65536
) (
  input  logic                      clk,
  input  logic                      rst,
  input  kls_cmd_t                  cmd,
  input  logic signed [VALUE_W-1:0] sample_value,
  input  logic                      kth_rank_we,
  input  logic        [CFG_W-1:0]   kth_rank_wdata,
  output logic signed [VALUE_W-1:0] kth_value,
  output logic                      status
);

  localparam int IDX_W  = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1;
  localparam int KW     = ($clog2(MAX_RANK + 1) > CFG_W) ? $clog2(MAX_RANK + 1) : CFG_W;
  localparam int IW     = $clog2(MAX_ITEMS + 1);
  localparam int CW     = (IW > KW) ? IW : KW;
  localparam int SECOND = (MAX_RANK > 1) ? 1 : 0;

  logic        [CFG_W-1:0]   kth_rank;
  logic        [KW-1:0]      rank_ext;
  logic        [KW-1:0]      rank_eff;
  logic        [IDX_W-1:0]   rank_idx;
  logic signed [VALUE_W-1:0] cell_value [MAX_RANK];
  logic        [MAX_RANK-1:0] cell_full;
  logic        [MAX_RANK-1:0] cell_stay;
  logic        [IW-1:0]      items_seen;
  logic signed [VALUE_W-1:0] sel_value;
  logic                      sel_full;
  logic                      set_short;

  // rank register
  always_ff @(posedge clk) begin
    if (rst) begin
      kth_rank <= CFG_W'(1);
    end else if (kth_rank_we) begin
      kth_rank <= kth_rank_wdata;
    end
  end

  // clamp rank into 1..MAX_RANK
  always_comb begin
    rank_ext = KW'(kth_rank);
    if (rank_ext == '0) begin
      rank_eff = KW'(1);
    end else if (rank_ext > KW'(MAX_RANK)) begin
      rank_eff = KW'(MAX_RANK);
    end else begin
      rank_eff = rank_ext;
    end
    rank_idx = IDX_W'(rank_eff - KW'(1));
  end

  // compare-and-shift chain, largest value in cell 0
  for (genvar i = 0; i < MAX_RANK; i++) begin : g_cell
    assign cell_stay[i] = cell_full[i] && !(sample_value > cell_value[i]);

    if (i == 0) begin : g_head
      always_ff @(posedge clk) begin
        if (cmd.insert && !cell_stay[i]) begin
          cell_value[i] <= sample_value;
        end
      end

      always_ff @(posedge clk) begin
        if (rst || cmd.report) begin
          cell_full[i] <= 1'b0;
        end else if (cmd.insert && !cell_stay[i]) begin
          cell_full[i] <= 1'b1;
        end
      end
    end else begin : g_body
      // take the sample where the cell above keeps its value, else shift down
      always_ff @(posedge clk) begin
        if (cmd.insert && !cell_stay[i]) begin
          if (cell_stay[i-1]) begin
            cell_value[i] <= sample_value;
          end else begin
            cell_value[i] <= cell_value[i-1];
          end
        end
      end

      always_ff @(posedge clk) begin
        if (rst || cmd.report) begin
          cell_full[i] <= 1'b0;
        end else if (cmd.insert && !cell_stay[i]) begin
          cell_full[i] <= cell_full[i-1];
        end
      end
    end
  end

  // saturating item count of the current set
  always_ff @(posedge clk) begin
    if (rst || cmd.report) begin
      items_seen <= '0;
    end else if (cmd.insert && (items_seen < IW'(MAX_ITEMS))) begin
      items_seen <= items_seen + IW'(1);
    end
  end

  // pick the k-th cell
  assign sel_value = cell_value[rank_idx];
  assign sel_full  = cell_full[rank_idx];
  assign set_short = (CW'(items_seen) < CW'(rank_eff)) || !sel_full;

  // result register
  always_ff @(posedge clk) begin
    if (cmd.report) begin
      kth_value <= set_short ? '0 : sel_value;
      status    <= set_short ? STATUS_SHORT : STATUS_OK;
    end
  end

`ifndef SYNTH
  a_report_clears: assert property (@(posedge clk) disable iff (rst)
    cmd.report |=> (cell_full[0] == 1'b0) && (items_seen == '0))
    else $error("chain not cleared after report");

  a_insert_fills_head: assert property (@(posedge clk) disable iff (rst)
    cmd.insert |=> cell_full[0])
    else $error("head cell empty after insert");

  a_chain_sorted: assert property (@(posedge clk) disable iff (rst)
    cell_full[SECOND] |-> (cell_full[0] && !(cell_value[SECOND] > cell_value[0])))
    else $error("chain out of order");
`endif

endmodule

[hw/rtl/kls_ctrl.sv]
module kls_ctrl import kls_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     s_tvalid,
  input  logic     s_tlast,
  output logic     s_tready,
  output logic     m_tvalid,
  input  logic     m_tready,
  output kls_cmd_t cmd
);

  localparam logic [0:0] ST_RUN    = 1'b0;
  localparam logic [0:0] ST_REPORT = 1'b1;

  logic [0:0] state;
  logic [0:0] state_next;
  logic       accept;
  logic       out_free;

  assign s_tready = (state == ST_RUN);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  // commands
  always_comb begin
    cmd.insert = accept;
    cmd.report = (state == ST_REPORT) && out_free;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_RUN: begin
        if (accept && s_tlast) begin
          state_next = ST_REPORT;
        end
      end
      ST_REPORT: begin
        if (out_free) begin
          state_next = ST_RUN;
        end
      end
      default: begin
        state_next = ST_RUN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_RUN;
    end else begin
      state <= state_next;
    end
  end

  // output beat valid
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.report) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

`ifndef SYNTH
  a_last_goes_report: assert property (@(posedge clk) disable iff (rst)
    (accept && s_tlast) |=> (state == ST_REPORT))
    else $error("last beat did not start report");

  a_report_shows_result: assert property (@(posedge clk) disable iff (rst)
    cmd.report |=> (m_tvalid && (state == ST_RUN)))
    else $error("report did not produce a result beat");

  a_no_insert_on_report: assert property (@(posedge clk) disable iff (rst)
    !(cmd.insert && cmd.report))
    else $error("insert and report in the same cycle");
`endif

endmodule

[hw/rtl/kth_largest_top_k_selector.sv]
// channel   | dir | handshake          | payload
// s_*       | in  | s_tvalid/s_tready  | s_tdata = sample_value, s_tlast = last_item
// m_*       | out | m_tvalid/m_tready  | m_tdata = kth_value, m_tuser = status
// kth_rank  | in  | kth_rank_we        | kth_rank_wdata = rank k
//
// one input beat per cycle while a set streams in; the compare-and-shift chain
// inserts each accepted value directly into its cells
// the last beat of a set moves to a report state, which holds off input and lasts while m_tready holds off
// a finished result, since the result register has a single slot
// rst is synchronous: chain empty, count zero, rank 1, no result pending
module kth_largest_top_k_selector import kls_pkg::*; #(
  parameter int              MAX_RANK  = 64,
  parameter longint unsigned MAX_ITEMS = 65536
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [VALUE_W-1:0] s_tdata,         // [31:0] sample_value
  input  logic               s_tlast,
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [VALUE_W-1:0] m_tdata,         // [31:0] kth_value
  output logic               m_tuser,         // [0] status
  input  logic               kth_rank_we,
  input  logic [CFG_W-1:0]   kth_rank_wdata
);

  kls_cmd_t                  cmd;
  logic signed [VALUE_W-1:0] kth_value;

  // control
  kls_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tlast  (s_tlast),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd)
  );

  // chain and result
  kls_datapath #(
    .MAX_RANK  (MAX_RANK),
    .MAX_ITEMS (MAX_ITEMS)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sample_value   (s_tdata),
    .kth_rank_we    (kth_rank_we),
    .kth_rank_wdata (kth_rank_wdata),
    .kth_value      (kth_value),
    .status         (m_tuser)
  );

  assign m_tdata = kth_value;

endmodule

[verif/kls_tb_pkg.sv]
package kls_tb_pkg;
  import kls_pkg::*;

  localparam int          CHAIN_DEPTH = 64;
  localparam int unsigned SEEN_CAP    = 65536;
  localparam int          REPORT_CAP  = 10;

  // one finished set: the k-th largest value and its status
  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               status;
  } kth_answer_t;

  // keeps its own ranked chain and the answers the block still owes
  class kth_answer_board;
    logic signed [VALUE_W-1:0] ranked[CHAIN_DEPTH];
    bit                        held[CHAIN_DEPTH];
    int unsigned               seen;
    logic [CFG_W-1:0]          rank;
    kth_answer_t               owed[$];
    int                        mismatches;
    int                        answers_checked;
    int                        short_sets;
    int                        rank_writes;

    function new();
      rank            = CFG_W'(1);
      mismatches      = 0;
      answers_checked = 0;
      short_sets      = 0;
      rank_writes     = 0;
      clear_chain();
    endfunction

    function void clear_chain();
      foreach (ranked[i]) begin
        ranked[i] = '0;
        held[i]   = 1'b0;
      end
      seen = 0;
    endfunction

    function void set_rank(logic [CFG_W-1:0] k);
      rank = k;
      rank_writes++;
    endfunction

    // rank as the block applies it: zero means one, capped at the chain depth
    function int applied_rank();
      int k;
      k = rank;
      if (k < 1) k = 1;
      if (k > CHAIN_DEPTH) k = CHAIN_DEPTH;
      return k;
    endfunction

    // walk down past every held value not below v, then shift the tail down
    function void insert_ranked(logic signed [VALUE_W-1:0] v);
      int pos;
      pos = 0;
      while (pos < CHAIN_DEPTH && held[pos] && !(v > ranked[pos])) pos++;
      if (pos >= CHAIN_DEPTH) return;
      for (int i = CHAIN_DEPTH - 1; i > pos; i--) begin
        ranked[i] = ranked[i-1];
        held[i]   = held[i-1];
      end
      ranked[pos] = v;
      held[pos]   = 1'b1;
    endfunction

    // accepted input beat
    function void note_sample(logic [VALUE_W-1:0] v, logic last);
      kth_answer_t ans;
      int          k;
      insert_ranked(v);
      if (seen < SEEN_CAP) seen++;
      if (!last) return;
      k = applied_rank();
      if (seen < k || !held[k-1]) begin
        ans.value  = '0;
        ans.status = STATUS_SHORT;
        short_sets++;
      end else begin
        ans.value  = ranked[k-1];
        ans.status = STATUS_OK;
      end
      owed.push_back(ans);
      clear_chain();
    endfunction

    function void report(string msg);
      mismatches++;
      if (mismatches <= REPORT_CAP) $display("mismatch: %s", msg);
    endfunction

    // accepted output beat against the oldest owed answer
    function void check_answer(logic [VALUE_W-1:0] v, logic st);
      kth_answer_t ans;
      if (owed.size() == 0) begin
        report($sformatf("unexpected result value=%0d status=%0b", $signed(v), st));
        return;
      end
      ans = owed.pop_front();
      answers_checked++;
      if (v !== ans.value || st !== ans.status)
        report($sformatf("result %0d: expected value=%0d status=%0b, got value=%0d status=%0b",
                         answers_checked, $signed(ans.value), ans.status, $signed(v), st));
    endfunction

    function int pending();
      return owed.size();
    endfunction
  endclass

endpackage

[verif/tb_kth_largest_top_k_selector.sv]
module tb_kth_largest_top_k_selector;
  import kls_pkg::*;
  import kls_tb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int          SETTLE_CYCLES = 12;
  localparam int          HOLD_CYCLES   = 400;
  localparam int          RANDOM_ITEMS  = 1000;
  localparam int          MIN_ANSWERS   = 48;
  localparam longint      CYCLE_LIMIT   = 1500000;

  localparam logic [VALUE_W-1:0] VMAX = 32'h7FFF_FFFF;
  localparam logic [VALUE_W-1:0] VMIN = 32'h8000_0000;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic [VALUE_W-1:0] s_tdata = '0;         // [31:0] sample_value
  logic               s_tlast = 1'b0;
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic [VALUE_W-1:0] m_tdata;              // [31:0] kth_value
  logic               m_tuser;              // [0] status
  logic               kth_rank_we = 1'b0;
  logic [CFG_W-1:0]   kth_rank_wdata = '0;

  kth_answer_board answers = new();

  longint cycles = 0;
  int     samples_sent = 0;
  int     sets_sent = 0;
  int     burst_left = 0;
  bit     no_gaps = 1'b0;
  bit     hold_req = 1'b0;

  kth_largest_top_k_selector DUT (
    .clk            (clk),
    .rst            (rst),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .s_tlast        (s_tlast),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .m_tuser        (m_tuser),
    .kth_rank_we    (kth_rank_we),
    .kth_rank_wdata (kth_rank_wdata)
  );

  // clock
  always #5 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // result beats go to the board
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) answers.check_answer(m_tdata, m_tuser);
  end

  // receiver: stall pattern picked at random from five modes, plus long hold-offs on request
  initial begin
    int hold_left;
    int mode;
    int mode_left;
    hold_left = 0;
    mode      = 0;
    mode_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 4);
        mode_left = 50;
      end
      mode_left--;
      if (rst) begin
        m_tready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        case (mode)
          0: m_tready <= 1'b1;
          1: m_tready <= 1'($urandom_range(0, 1));
          2: m_tready <= ($urandom_range(0, 7) != 0);
          3: m_tready <= ($urandom_range(0, 3) == 0);
          default: m_tready <= cycles[1];
        endcase
      end
    end
  end

  // one input beat; random gaps fall between bursts
  task automatic send_sample(logic [VALUE_W-1:0] v, logic last);
    int gap;
    s_tvalid <= 1'b1;
    s_tdata  <= v;
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    answers.note_sample(v, last);
    samples_sent++;
    if (last) sets_sent++;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0 || no_gaps) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  // pause input until nothing is owed, then let the block settle
  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (answers.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_rank(logic [CFG_W-1:0] k);
    drain_results();
    kth_rank_we    <= 1'b1;
    kth_rank_wdata <= k;
    @(posedge clk);
    answers.set_rank(k);
    kth_rank_we    <= 1'b0;
  endtask

  function automatic logic [VALUE_W-1:0] pick_value(int mode);
    case (mode)
      0: return $urandom;
      1: return $urandom_range(0, 16) - 8;
      2: begin
        case ($urandom_range(0, 4))
          0: return VMAX;
          1: return VMIN;
          2: return '0;
          3: return '1;
          default: return $urandom;
        endcase
      end
      default: return {{16{$urandom_range(0, 1) == 1}}, 16'($urandom)};
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] pick_rank();
    case ($urandom_range(0, 9))
      0: return CFG_W'(0);
      1: return CFG_W'(127);
      2: return CFG_W'(64);
      3: return CFG_W'(65);
      4, 5, 6: return CFG_W'($urandom_range(1, 4));
      7, 8: return CFG_W'($urandom_range(1, 64));
      default: return CFG_W'($urandom_range(0, 127));
    endcase
  endfunction

  // set lengths mostly at or just above the rank, with short and long ones mixed in
  function automatic int pick_len(int k);
    case ($urandom_range(0, 9))
      0: return $urandom_range(1, k);
      1: return 1;
      8: return $urandom_range(k, k + 80);
      9: return $urandom_range(1, 150);
      default: return k + $urandom_range(0, 12);
    endcase
  endfunction

  task automatic run_set(int len, int mode);
    for (int i = 0; i < len; i++) send_sample(pick_value(mode), i == len - 1);
  endtask

  initial begin
    int  sets_at_rank;
    bit  pressure_done;
    sets_at_rank  = 0;
    pressure_done = 1'b0;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset rank of one, extremes and sign handling
    send_sample(VMAX, 1'b1);
    send_sample(VMIN, 1'b1);
    send_sample('1, 1'b0);
    send_sample('0, 1'b0);
    send_sample(32'd1, 1'b1);
    // rank zero acts as one
    write_rank(CFG_W'(0));
    send_sample(32'd5, 1'b0);
    send_sample(32'd9, 1'b0);
    send_sample(-32'sd2, 1'b1);
    // equal values count separately, short set, extremes at rank three
    write_rank(CFG_W'(3));
    send_sample(32'd7, 1'b0);
    send_sample(32'd7, 1'b0);
    send_sample(32'd7, 1'b1);
    send_sample(32'd4, 1'b0);
    send_sample(32'd8, 1'b1);
    send_sample(VMIN, 1'b0);
    send_sample(VMAX, 1'b0);
    send_sample(VMIN, 1'b0);
    send_sample(VMIN, 1'b1);
    // rank above the chain depth is capped
    write_rank(CFG_W'(127));
    send_sample(32'd1, 1'b0);
    send_sample(32'd2, 1'b1);
    write_rank(CFG_W'(65));
    send_sample(VMAX, 1'b1);

    // random sets with rank changes between phases
    while (samples_sent < RANDOM_ITEMS || answers.answers_checked < MIN_ANSWERS) begin
      if (sets_at_rank == 0) begin
        write_rank(pick_rank());
        sets_at_rank = $urandom_range(1, 6);
      end
      if (!pressure_done && samples_sent > RANDOM_ITEMS / 2) begin
        // receiver holds off while short sets keep coming, so the input backs up
        pressure_done = 1'b1;
        hold_req = 1'b1;
        no_gaps  = 1'b1;
        repeat (8) run_set($urandom_range(1, 3), $urandom_range(0, 3));
        no_gaps  = 1'b0;
        drain_results();
      end
      run_set(pick_len(answers.applied_rank()), $urandom_range(0, 3));
      sets_at_rank--;
    end

    drain_results();
    $display("covered %0d samples in %0d sets, %0d rank writes, %0d answers checked",
             samples_sent, sets_sent, answers.rank_writes, answers.answers_checked);
    $display("short sets flagged: %0d, mismatches: %0d",
             answers.short_sets, answers.mismatches);
    if (answers.mismatches == 0 && answers.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
